// ===== rtl/core/crau_pkg.sv =====
// Shared types and constants for the contiguous run allocator.
`default_nettype none
package crau_pkg;

   localparam int unsigned CRAU_CLUSTERS = 4096;
   localparam int unsigned ADDR_W        = 12;
   localparam int unsigned RUN_LEN_W     = 13;
   localparam int unsigned CNT_W         = 13;
   localparam int unsigned START_W       = 12;
   localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;

   localparam logic [1:0] CMD_RESERVE = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_MARK    = 2'd2;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [ADDR_W-1:0]    cluster_addr;
      logic [RUN_LEN_W-1:0] run_length;
      logic                 mark_free;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [START_W-1:0] first_cluster;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic used_we;
      logic used_wd;
      logic rsv_we;
      logic rsv_wd;
   } map_ctl_type;

   typedef struct packed {
      logic               valid;
      logic               ok;
      logic [START_W-1:0] start;
      logic               clearing;
   } fin_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FILL,
      ST_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      FILL_RSV_SET,
      FILL_RSV_CLR,
      FILL_USED_SET,
      FILL_USED_CLR
   } fill_mode_type;

endpackage
`default_nettype wire

// ===== rtl/core/crau_map.sv =====
// Cluster map memories: one used bit and one reserved bit per cluster.
`default_nettype none
module crau_map #(
   parameter int unsigned CLUSTERS = crau_pkg::CRAU_CLUSTERS
) (
   input  wire logic                        clock,
   input  wire crau_pkg::map_ctl_type       map_ctl,
   input  wire logic [$clog2(CLUSTERS)-1:0] map_addr,
   output      logic                        used_q,
   output      logic                        rsv_q
);
   import crau_pkg::*;

   logic used_mem [CLUSTERS];
   logic rsv_mem  [CLUSTERS];

   always_ff @(posedge clock) begin
      if (map_ctl.used_we) begin
         used_mem[map_addr] <= map_ctl.used_wd;
      end
      if (map_ctl.rd_en) begin
         used_q <= used_mem[map_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (map_ctl.rsv_we) begin
         rsv_mem[map_addr] <= map_ctl.rsv_wd;
      end
      if (map_ctl.rd_en) begin
         rsv_q <= rsv_mem[map_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/crau_seq.sv =====
// Command sequencer: clearing pass, next-fit scan and range writes over the map.
`default_nettype none
module crau_seq #(
   parameter int unsigned CLUSTERS = crau_pkg::CRAU_CLUSTERS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire crau_pkg::req_type             req_payload,
   input  wire logic [crau_pkg::CNT_W-1:0]    cluster_count,
   input  wire logic                          fin_take,
   output      crau_pkg::fin_type             fin,
   output      crau_pkg::map_ctl_type         map_ctl,
   output      logic [$clog2(CLUSTERS)-1:0]   map_addr,
   input  wire logic                          used_q,
   input  wire logic                          rsv_q
);
   import crau_pkg::*;

   localparam int unsigned CW = $clog2(CLUSTERS + 1);
   localparam int unsigned AW = $clog2(CLUSTERS);
   localparam int unsigned XW = ((CW > RUN_LEN_W) ? CW : RUN_LEN_W) + 1;

   seq_state_type state_ff, state_in;
   fill_mode_type fill_mode_ff, fill_mode_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] end_ff, end_in;
   logic [CW-1:0] pend_idx_ff, pend_idx_in;
   logic [CW-1:0] run_ff, run_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] pbase_ff, pbase_in;
   logic          pend_ff, pend_in;
   logic          phase2_ff, phase2_in;
   logic          ok_ff, ok_in;
   logic [START_W-1:0] start_ff, start_in;

   logic [XW-1:0] cc_x, n_x, len_x, addr_x, aend_x, e2_x, end2_x, s_x;
   logic [CW-1:0] n_c, p_eff, run_inc, s_c, sl_c, end2_c;
   logic          accept, rsv_ok, rng_ok, issue, avail, found, scan_over;
   logic          wrap_pending, fill_last, clear_last;

   always_comb begin
      cc_x   = XW'(cluster_count);
      n_x    = (cc_x < XW'(2)) ? XW'(2) : ((cc_x > XW'(CLUSTERS)) ? XW'(CLUSTERS) : cc_x);
      n_c    = n_x[CW-1:0];
      len_x  = XW'(req_payload.run_length);
      addr_x = XW'(req_payload.cluster_addr);
      aend_x = addr_x + len_x;
      accept = req_valid && req_ready;
      rsv_ok = (len_x != '0) && (len_x <= n_x);
      rng_ok = aend_x <= n_x;
      p_eff  = (XW'(ptr_ff) >= n_x) ? '0 : ptr_ff;

      issue     = (state_ff == ST_SCAN) && (idx_ff < end_ff);
      avail     = !used_q && !rsv_q;
      run_inc   = run_ff + CW'(1);
      found     = (state_ff == ST_SCAN) && pend_ff && avail && (run_inc == len_ff);
      s_c       = pend_idx_ff + CW'(1) - len_ff;
      s_x       = XW'(s_c);
      sl_c      = s_c + len_ff;
      scan_over = (state_ff == ST_SCAN) && !pend_ff && !issue;
      wrap_pending = !phase2_ff && (pbase_ff != '0);

      // second pass may run over the pointer but starts strictly below it
      e2_x   = XW'(pbase_ff) + XW'(len_ff) - XW'(1);
      end2_x = (e2_x > n_x) ? n_x : e2_x;
      end2_c = end2_x[CW-1:0];

      fill_last  = (idx_ff + CW'(1)) == end_ff;
      clear_last = idx_ff == CW'(CLUSTERS - 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_payload.cmd == CMD_RESERVE) begin
                  state_in = rsv_ok ? ST_SCAN : ST_DONE;
               end else if (req_payload.cmd == CMD_RELEASE || req_payload.cmd == CMD_MARK) begin
                  state_in = (rng_ok && len_x != '0) ? ST_FILL : ST_DONE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (found) begin
               state_in = ST_FILL;
            end else if (scan_over && !wrap_pending) begin
               state_in = ST_DONE;
            end
         end
         ST_FILL: begin
            if (fill_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (fin_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      idx_in       = idx_ff;
      end_in       = end_ff;
      pend_idx_in  = pend_idx_ff;
      run_in       = run_ff;
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      pbase_in     = pbase_ff;
      pend_in      = 1'b0;
      phase2_in    = phase2_ff;
      ok_in        = ok_ff;
      start_in     = start_ff;
      fill_mode_in = fill_mode_ff;
      case (state_ff)
         ST_CLEAR: begin
            idx_in = idx_ff + CW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               len_in    = len_x[CW-1:0];
               run_in    = '0;
               phase2_in = 1'b0;
               ok_in     = 1'b0;
               start_in  = '0;
               if (req_payload.cmd == CMD_RESERVE) begin
                  idx_in   = p_eff;
                  end_in   = n_c;
                  pbase_in = p_eff;
               end else if (req_payload.cmd == CMD_RELEASE || req_payload.cmd == CMD_MARK) begin
                  ok_in  = rng_ok;
                  idx_in = addr_x[CW-1:0];
                  end_in = aend_x[CW-1:0];
                  if (req_payload.cmd == CMD_RELEASE) begin
                     fill_mode_in = FILL_RSV_CLR;
                  end else if (req_payload.mark_free) begin
                     fill_mode_in = FILL_USED_CLR;
                  end else begin
                     fill_mode_in = FILL_USED_SET;
                  end
               end
            end
         end
         ST_SCAN: begin
            pend_in = issue;
            if (issue) begin
               pend_idx_in = idx_ff;
               idx_in      = idx_ff + CW'(1);
            end
            if (pend_ff) begin
               run_in = avail ? run_inc : '0;
            end
            if (found) begin
               pend_in      = 1'b0;
               idx_in       = s_c;
               end_in       = sl_c;
               ok_in        = 1'b1;
               start_in     = s_x[START_W-1:0];
               ptr_in       = (sl_c == n_c) ? '0 : sl_c;
               fill_mode_in = FILL_RSV_SET;
            end else if (scan_over && wrap_pending) begin
               phase2_in = 1'b1;
               idx_in    = '0;
               end_in    = end2_c;
               run_in    = '0;
            end
         end
         ST_FILL: begin
            idx_in = idx_ff + CW'(1);
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      map_ctl        = '0;
      map_addr       = idx_ff[AW-1:0];
      req_ready      = 1'b0;
      fin.valid      = 1'b0;
      fin.ok         = ok_ff;
      fin.start      = start_ff;
      fin.clearing   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            map_ctl.used_we = 1'b1;
            map_ctl.rsv_we  = 1'b1;
            fin.clearing    = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCAN: begin
            map_ctl.rd_en = issue;
         end
         ST_FILL: begin
            case (fill_mode_ff)
               FILL_RSV_SET: begin
                  map_ctl.rsv_we = 1'b1;
                  map_ctl.rsv_wd = 1'b1;
               end
               FILL_RSV_CLR: begin
                  map_ctl.rsv_we = 1'b1;
               end
               FILL_USED_SET: begin
                  map_ctl.used_we = 1'b1;
                  map_ctl.used_wd = 1'b1;
               end
               FILL_USED_CLR: begin
                  map_ctl.used_we = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_DONE: begin
            fin.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         idx_ff    <= '0;
         ptr_ff    <= '0;
         pend_ff   <= 1'b0;
         phase2_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         ptr_ff    <= ptr_in;
         pend_ff   <= pend_in;
         phase2_ff <= phase2_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff       <= end_in;
      pend_idx_ff  <= pend_idx_in;
      run_ff       <= run_in;
      len_ff       <= len_in;
      pbase_ff     <= pbase_in;
      ok_ff        <= ok_in;
      start_ff     <= start_in;
      fill_mode_ff <= fill_mode_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/contiguous_run_allocator_unit.sv =====
// Top level of the next-fit contiguous run allocator.
// The allocator keeps a used bit and a reserved bit for every cluster in two
// single-port synchronous memories and handles one command at a time. With n
// the usable cluster count and L the run length, a reserve beat scans the map
// one cluster per cycle from the next-fit pointer to the end of the usable
// range, then, if nothing was found and the pointer is not 0, from cluster 0
// up to but not including pointer + L - 1 or n, whichever is lower; a run may
// cross the pointer but never wraps. A found run is then written reserved one
// cluster per cycle and the pointer moves past it. The two passes read up to
// n + L - 1 clusters, then L reserved bits are written; release and mark write
// L clusters. After reset the block clears both maps (all CLUSTERS entries,
// 4096 by default) with req_ready low; csr writes are taken throughout. The
// result beat sits in an output register, so the next command is accepted
// while an earlier result waits on rsp_ready. The cluster count register must
// be written only while the block is idle; the block itself does not enforce
// this. The sequencer saturates the value it uses into [2, CLUSTERS].
`default_nettype none
module contiguous_run_allocator_unit #(
   parameter int unsigned CLUSTERS = crau_pkg::CRAU_CLUSTERS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire crau_pkg::req_type          req_payload,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      crau_pkg::rsp_type          rsp_payload,
   input  wire logic                       csr_we,
   input  wire logic [crau_pkg::CNT_W-1:0] csr_wdata
);
   import crau_pkg::*;

   localparam int unsigned AW = $clog2(CLUSTERS);

   logic [CNT_W-1:0]  cluster_count_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;
   fin_type           fin;
   logic              fin_take;
   map_ctl_type       map_ctl;
   logic [AW-1:0]     map_addr;
   logic              used_q, rsv_q;

   // csr: cluster count, taken on any write-enable cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_count_ff <= CNT_RESET;
      end else if (csr_we) begin
         cluster_count_ff <= csr_wdata;
      end
   end

   crau_seq #(
      .CLUSTERS (CLUSTERS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .cluster_count (cluster_count_ff),
      .fin_take      (fin_take),
      .fin           (fin),
      .map_ctl       (map_ctl),
      .map_addr      (map_addr),
      .used_q        (used_q),
      .rsv_q         (rsv_q)
   );

   crau_map #(
      .CLUSTERS (CLUSTERS)
   ) u_map (
      .clock    (clock),
      .map_ctl  (map_ctl),
      .map_addr (map_addr),
      .used_q   (used_q),
      .rsv_q    (rsv_q)
   );

   // output register: load a finished result once the slot is empty or draining
   always_comb begin
      fin_take       = fin.valid && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (fin_take) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.ok            = fin.ok;
         rsp_payload_in.first_cluster = fin.start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // no command beat during the clearing pass
   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      fin.clearing |-> !req_ready)
      else $error("req_ready high during map clearing pass");

   // one command in flight: an accepted beat closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a command is in flight");

   // a failed command reports start cluster zero
   a_fail_start_zero: assert property (@(posedge clock) disable iff (reset)
      (fin.valid && !fin.ok) |-> (fin.start == '0))
      else $error("failed command carries a non-zero start cluster");

   // a result is loaded only into a free or draining output slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      fin_take |-> (!rsp_valid || rsp_ready))
      else $error("result overwrote a pending response beat");

endmodule
`default_nettype wire
